@@ rtl/dbt_pkg.sv @@
package dbt_pkg;

    localparam int START_W   = 22;
    localparam int COUNT_W   = 23;
    localparam int BS_W      = 17;
    localparam int TOTAL_W   = 23;
    localparam int END_W     = 24;
    localparam int OFF_W     = 25;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_EPB   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = CFG_IDX_W'(1);

    localparam logic [BS_W-1:0]    EPB_RESET   = BS_W'(1024);
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(65536);

    typedef enum logic [1:0] {
        FN_MARK  = 2'd0,
        FN_CLEAR = 2'd1,
        FN_SCAN  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_ENTRY = 2'd1,
        ST_NONE  = 2'd2,
        ST_CLIP  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_MARK,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_LAST,
        S_RESP
    } state_t;

    typedef struct packed {
        logic init;
        logic step;
    } walk_cmd_t;

    typedef struct packed {
        logic               active;
        logic               covered;
        logic               last_idx;
        logic               clip;
        logic [BS_W-1:0]    len;
        logic [START_W-1:0] off;
    } walk_stat_t;

    typedef struct packed {
        status_t            status;
        logic [START_W-1:0] block_start;
        logic [BS_W-1:0]    block_len;
        logic               last;
    } emit_t;

endpackage

@@ rtl/dbt_if.sv @@
interface dbt_req_if import dbt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [START_W-1:0] start_elem;
    logic [COUNT_W-1:0] elem_count;

    modport source (output valid, func, start_elem, elem_count, input ready);
    modport sink   (input valid, func, start_elem, elem_count, output ready);
endinterface

interface dbt_res_if import dbt_pkg::*; #(parameter int TOT_W = 7) ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [START_W-1:0] block_start;
    logic [BS_W-1:0]    block_len;
    logic [TOT_W-1:0]   dirty_total;
    logic               last;

    modport source (output valid, status, block_start, block_len, dirty_total, last,
                    input ready);
    modport sink   (input valid, status, block_start, block_len, dirty_total, last,
                    output ready);
endinterface

interface dbt_cfg_if import dbt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/dbt_bitmap.sv @@
module dbt_bitmap #(
    parameter int NUM_BLOCKS = 64,
    parameter int IDX_W      = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_data
);

    logic mem [NUM_BLOCKS];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dbt_stride.sv @@
module dbt_stride import dbt_pkg::*; #(
    parameter int NUM_BLOCKS = 64,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  walk_cmd_t          cmd,
    input  logic [BS_W-1:0]    bs,
    input  logic [TOTAL_W-1:0] total,
    input  logic [START_W-1:0] start,
    input  logic [END_W-1:0]   stop,
    output logic [IDX_W-1:0]   idx,
    output walk_stat_t         stat
);

    logic [OFF_W-1:0] off_reg;
    logic [OFF_W-1:0] off_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [OFF_W-1:0] nxt;
    logic [OFF_W-1:0] total_x;
    logic [OFF_W-1:0] diff;

    // one block stride: offset of the next block and bounds of this one
    assign total_x  = OFF_W'(total);
    assign nxt      = off_reg + OFF_W'(bs);
    assign diff     = total_x - off_reg;
    assign off_next = cmd.init ? '0 : nxt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.init)
        begin
            off_reg <= off_next;
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            off_reg <= off_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        idx           = cnt_reg[IDX_W-1:0];
        stat.active   = (off_reg < total_x) && (cnt_reg != CNT_W'(NUM_BLOCKS));
        stat.covered  = (nxt > OFF_W'(start)) && (off_reg <= OFF_W'(stop));
        stat.last_idx = (cnt_reg == CNT_W'(NUM_BLOCKS - 1));
        // at the end of a walk the offset lies at or past the active bound
        stat.clip     = (OFF_W'(stop) >= off_reg);
        stat.len      = (nxt > total_x) ? diff[BS_W-1:0] : bs;
        stat.off      = off_reg[START_W-1:0];
    end

endmodule

@@ rtl/dbt_out_reg.sv @@
module dbt_out_reg import dbt_pkg::*; #(
    parameter int TOT_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             emit_valid,
    input  emit_t            emit,
    input  logic [TOT_W-1:0] emit_total,
    output logic             emit_ack,
    dbt_res_if.source        res
);

    logic             valid_reg;
    emit_t            data_reg;
    logic [TOT_W-1:0] total_reg;

    assign emit_ack = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit_ack)
        begin
            valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ack && emit_valid)
        begin
            data_reg  <= emit;
            total_reg <= emit_total;
        end
    end

    assign res.valid       = valid_reg;
    assign res.status      = data_reg.status;
    assign res.block_start = data_reg.block_start;
    assign res.block_len   = data_reg.block_len;
    assign res.dirty_total = total_reg;
    assign res.last        = data_reg.last;

endmodule

@@ rtl/dbt_seq.sv @@
module dbt_seq import dbt_pkg::*; #(
    parameter int TOT_W = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_func,
    input  logic [START_W-1:0] req_start,
    input  logic [COUNT_W-1:0] req_count,
    output logic               req_ready,
    input  walk_stat_t         stat,
    output walk_cmd_t          cmd,
    output logic [START_W-1:0] start,
    output logic [END_W-1:0]   stop,
    input  logic               rd_data,
    output logic               wr_en,
    output logic               wr_data,
    output logic               emit_valid,
    output emit_t              emit,
    output logic [TOT_W-1:0]   emit_total,
    input  logic               emit_ack
);

    state_t             state_reg;
    state_t             state_next;
    logic               pend_valid_reg;
    logic [START_W-1:0] pend_start_reg;
    logic [BS_W-1:0]    pend_len_reg;
    logic [TOT_W-1:0]   pend_tot_reg;
    status_t            resp_reg;
    logic [START_W-1:0] start_reg;
    logic [END_W-1:0]   stop_reg;
    logic               req_fire;
    logic               chk_adv;

    assign req_fire = req_valid && req_ready;
    assign chk_adv  = !rd_data || !pend_valid_reg || emit_ack;
    assign start    = start_reg;
    assign stop     = stop_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_WIPE:
            begin
                if (stat.last_idx)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (func_t'(req_func))
                        FN_MARK:  state_next = (req_count == '0) ? S_RESP : S_MARK;
                        FN_CLEAR: state_next = S_CLEAR;
                        FN_SCAN:  state_next = S_SCAN_RD;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_MARK:
            begin
                if (!stat.active)
                begin
                    state_next = S_RESP;
                end
            end
            S_CLEAR:
            begin
                if (stat.last_idx)
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN_RD:
            begin
                if (!stat.active)
                begin
                    state_next = pend_valid_reg ? S_SCAN_LAST : S_RESP;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (chk_adv)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_LAST, S_RESP:
            begin
                if (emit_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready        = 1'b0;
        cmd.init         = 1'b0;
        cmd.step         = 1'b0;
        wr_en            = 1'b0;
        wr_data          = 1'b0;
        emit_valid       = 1'b0;
        emit.status      = ST_ENTRY;
        emit.block_start = pend_start_reg;
        emit.block_len   = pend_len_reg;
        emit.last        = 1'b0;
        emit_total       = pend_tot_reg;
        unique case (state_reg)
            S_WIPE, S_CLEAR:
            begin
                cmd.step = 1'b1;
                wr_en    = 1'b1;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.init  = req_fire;
            end
            S_MARK:
            begin
                cmd.step = stat.active;
                wr_en    = stat.active && stat.covered;
                wr_data  = 1'b1;
            end
            S_SCAN_RD:
            begin
            end
            S_SCAN_CHK:
            begin
                cmd.step   = chk_adv;
                // flush the held entry only once a later one proves it is not last
                emit_valid = rd_data && pend_valid_reg;
            end
            S_SCAN_LAST:
            begin
                emit_valid = 1'b1;
                emit.last  = 1'b1;
            end
            S_RESP:
            begin
                emit_valid       = 1'b1;
                emit.status      = resp_reg;
                emit.block_start = '0;
                emit.block_len   = '0;
                emit.last        = 1'b1;
                emit_total       = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WIPE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN_CHK && rd_data && chk_adv)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            start_reg    <= req_start;
            stop_reg     <= END_W'(req_start) + END_W'(req_count) - END_W'(1);
            resp_reg     <= ST_DONE;
            pend_tot_reg <= '0;
        end
        if (state_reg == S_MARK && !stat.active)
        begin
            resp_reg <= stat.clip ? ST_CLIP : ST_DONE;
        end
        if (state_reg == S_SCAN_RD && !stat.active && !pend_valid_reg)
        begin
            resp_reg <= ST_NONE;
        end
        if (state_reg == S_SCAN_CHK && rd_data && chk_adv)
        begin
            pend_start_reg <= stat.off;
            pend_len_reg   <= stat.len;
            pend_tot_reg   <= pend_tot_reg + TOT_W'(1);
        end
    end

endmodule

@@ rtl/dirty_block_tracker.sv @@
// Sequence: mark walks the active blocks, one per cycle, then answers; clear
//   sweeps all NUM_BLOCKS blocks then answers; scan reads and then checks each
//   active block, and a stalled result holds the walk.
// Throughput: one request at a time, set by the block walk of the stride unit.
// Reset: registers return to 1024 and 65536; a wipe pass over all NUM_BLOCKS
//   blocks zeroes the bitmap, with req.ready low until it ends.
module dirty_block_tracker import dbt_pkg::*; #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    dbt_req_if.sink   req,
    dbt_res_if.source res,
    dbt_cfg_if.sink   cfg
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int TOT_W = $clog2(NUM_BLOCKS + 1);

    logic [BS_W-1:0]    epb_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [BS_W-1:0]    bs;
    walk_cmd_t          cmd;
    walk_stat_t         stat;
    logic [IDX_W-1:0]   idx;
    logic [START_W-1:0] start;
    logic [END_W-1:0]   stop;
    logic               rd_data;
    logic               wr_en;
    logic               wr_data;
    logic               emit_valid;
    emit_t              emit;
    logic [TOT_W-1:0]   emit_total;
    logic               emit_ack;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epb_reg   <= EPB_RESET;
            total_reg <= TOTAL_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_EPB:   epb_reg   <= cfg.data[BS_W-1:0];
                CFG_TOTAL: total_reg <= cfg.data[TOTAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // zero block size acts as one element per block
    assign bs = (epb_reg == '0) ? BS_W'(1) : epb_reg;

    dbt_seq #(
        .TOT_W (TOT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_func   (req.func),
        .req_start  (req.start_elem),
        .req_count  (req.elem_count),
        .req_ready  (req.ready),
        .stat       (stat),
        .cmd        (cmd),
        .start      (start),
        .stop       (stop),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .emit_valid (emit_valid),
        .emit       (emit),
        .emit_total (emit_total),
        .emit_ack   (emit_ack)
    );

    dbt_stride #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_stride (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .bs    (bs),
        .total (total_reg),
        .start (start),
        .stop  (stop),
        .idx   (idx),
        .stat  (stat)
    );

    dbt_bitmap #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx),
        .wr_data (wr_data),
        .rd_addr (idx),
        .rd_data (rd_data)
    );

    dbt_out_reg #(
        .TOT_W (TOT_W)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit       (emit),
        .emit_total (emit_total),
        .emit_ack   (emit_ack),
        .res        (res)
    );

endmodule

@@ rtl/dbt_checker.sv @@
module dbt_checker import dbt_pkg::*; #(
    parameter int TOT_W = 7
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         res_status,
    input logic [START_W-1:0] res_block_start,
    input logic [BS_W-1:0]    res_block_len,
    input logic [TOT_W-1:0]   res_dirty_total,
    input logic               res_last
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status)
            && $stable(res_block_start) && $stable(res_dirty_total) && $stable(res_last))
        else $error("result beat changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_ENTRY |-> res_last)
        else $error("single result without last");

    a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_ENTRY |->
            res_block_start == '0 && res_block_len == '0 && res_dirty_total == '0)
        else $error("nonzero fields on a plain result");

    a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_ENTRY |->
            res_block_len != '0 && res_dirty_total != '0)
        else $error("empty dirty block entry");

endmodule

bind dirty_block_tracker dbt_checker #(
    .TOT_W ($clog2(NUM_BLOCKS + 1))
) u_dbt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_block_start (res.block_start),
    .res_block_len   (res.block_len),
    .res_dirty_total (res.dirty_total),
    .res_last        (res.last)
);
